@@ sv/tclp_pkg.sv @@
// package for the text command line parser
// holds sizes, command and status codes, keyword table and result type
// no dependencies
package tclp_pkg;

    localparam int MAX_LINE  = 1024;
    localparam int ARG_SLOTS = 4;
    localparam int OUT_ARGS  = (ARG_SLOTS < 4) ? ARG_SLOTS : 4;
    localparam int KW_COUNT  = 5;
    localparam int TOK_W     = $clog2(ARG_SLOTS + 3);
    localparam int LEN_W     = $clog2(MAX_LINE + 1);

    typedef logic [2:0] cmd_t;
    typedef logic [1:0] status_t;

    localparam cmd_t CMD_REBOX   = 3'd0;
    localparam cmd_t CMD_CLOSE   = 3'd1;
    localparam cmd_t CMD_HIDE    = 3'd2;
    localparam cmd_t CMD_RELEASE = 3'd3;
    localparam cmd_t CMD_QUIT    = 3'd4;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_UNKNOWN = 2'd1;
    localparam status_t ST_ZERO_ID = 2'd2;
    localparam status_t ST_TOO_LNG = 2'd3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // keywords, left aligned, first character in the top byte
    localparam logic [55:0] KW_TEXT [KW_COUNT] = '{
        {"REBOX", 16'h0000},
        {"CLOSE", 16'h0000},
        {"HIDE", 24'h000000},
        {"RELEASE"},
        {"QUIT", 24'h000000}
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd5, 3'd5, 3'd4, 3'd7, 3'd4};

    typedef struct packed {
        cmd_t               command;
        status_t            status;
        logic signed [31:0] target_id;
        logic signed [31:0] arg_x;
        logic signed [31:0] arg_y;
        logic signed [31:0] arg_w;
        logic signed [31:0] arg_h;
    } result_t;

    // character at position pos of keyword k, zero past the end
    function automatic logic [7:0] kw_char(input int k, input logic [2:0] pos);
        logic [55:0] txt;
        int          sel;
        txt = KW_TEXT[k];
        sel = 6 - int'(pos);
        if (pos == 3'd7)
            return 8'h00;
        return txt[8*sel +: 8];
    endfunction

endpackage

@@ sv/tclp_if.sv @@
// valid/ready channel interfaces of the text command line parser
// byte channel and result channel; no dependencies
interface tclp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface tclp_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic [1:0]         status;
    logic signed [31:0] target_id;
    logic signed [31:0] arg_x;
    logic signed [31:0] arg_y;
    logic signed [31:0] arg_w;
    logic signed [31:0] arg_h;

    modport source (output valid, output command, output status, output target_id,
                    output arg_x, output arg_y, output arg_w, output arg_h, input ready);
    modport sink (input valid, input command, input status, input target_id,
                  input arg_x, input arg_y, input arg_w, input arg_h, output ready);
endinterface

@@ sv/text_command_line_parser_unit.sv @@
// text command line parser: one byte per request in, one result per line out
// a newline byte's result is registered into the output register, or into the skid stage while the output is held
// throughput: one byte every cycle; ready drops only while the skid stage is full
// reset: asynchronous active low, clears the line state and the valid flags of both result stages
// depends on tclp_pkg and tclp_if
module text_command_line_parser_unit (
    input logic       clk,
    input logic       rst_n,
    tclp_in_if.sink   rx,
    tclp_out_if.source res
);
    import tclp_pkg::*;

    typedef enum logic [1:0] {
        PH_LEAD   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    // line state
    logic [TOK_W-1:0]    token_index_reg, token_index_next;
    logic [KW_COUNT-1:0] keyword_match_reg, keyword_match_next;
    logic [2:0]          keyword_pos_reg, keyword_pos_next;
    logic [31:0]         number_accum_reg, number_accum_next;
    logic                number_neg_reg, number_neg_next;
    phase_t              phase_reg, phase_next;
    logic [31:0]         parsed_id_reg, parsed_id_next;
    logic [31:0]         parsed_args_reg [ARG_SLOTS];
    logic [31:0]         parsed_args_next [ARG_SLOTS];
    logic [LEN_W-1:0]    line_length_reg, line_length_next;
    logic                overflow_reg, overflow_next;
    cmd_t                line_cmd_reg, line_cmd_next;
    status_t             line_status_reg, line_status_next;

    // output register and skid stage
    result_t             out_data_reg, out_data_next;
    logic                out_valid_reg, out_valid_next;
    result_t             skid_data_reg, skid_data_next;
    logic                skid_valid_reg, skid_valid_next;

    logic                accept;
    logic [7:0]          c;
    logic                is_nl;
    logic                is_sp;
    logic                is_digit;
    logic                is_ws;
    logic [31:0]         tok_val;

    // effect of closing the current token
    logic [TOK_W-1:0]    et_tok_index;
    cmd_t                et_cmd;
    status_t             et_status;
    logic [31:0]         et_id;
    logic [31:0]         et_args [ARG_SLOTS];
    logic                kw_found;

    // result built at a newline
    status_t             fin_status;
    result_t             new_res;
    logic [31:0]         res_args [4];
    logic                out_free;

    assign rx.ready = !skid_valid_reg;
    assign accept   = rx.valid && rx.ready;
    assign c        = rx.rx_byte;
    assign is_nl    = (c == CH_NL);
    assign is_sp    = (c == CH_SPACE);
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_ws    = (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    assign tok_val  = number_neg_reg ? (32'd0 - number_accum_reg) : number_accum_reg;

    // token close: keyword decode on token 0, id or argument capture after it
    always_comb
    begin
        et_cmd    = line_cmd_reg;
        et_status = line_status_reg;
        et_id     = parsed_id_reg;
        kw_found  = 1'b0;
        for (int j = 0; j < ARG_SLOTS; j++)
            et_args[j] = parsed_args_reg[j];
        if (line_status_reg == ST_OK)
        begin
            if (token_index_reg == '0)
            begin
                // first matching keyword wins
                for (int k = 0; k < KW_COUNT; k++)
                begin
                    if (!kw_found && keyword_match_reg[k] && (keyword_pos_reg == KW_LEN[k]))
                    begin
                        kw_found = 1'b1;
                        et_cmd   = cmd_t'(k);
                    end
                end
                if (!kw_found)
                    et_status = ST_UNKNOWN;
            end
            else if (line_cmd_reg != CMD_QUIT)
            begin
                if (token_index_reg == TOK_W'(1))
                begin
                    et_id = tok_val;
                    if (tok_val == 32'd0)
                        et_status = ST_ZERO_ID;
                end
                else
                begin
                    for (int j = 0; j < ARG_SLOTS; j++)
                    begin
                        if (token_index_reg == TOK_W'(j + 2))
                            et_args[j] = tok_val;
                    end
                end
            end
        end
        if (token_index_reg < TOK_W'(ARG_SLOTS + 2))
            et_tok_index = token_index_reg + TOK_W'(1);
        else
            et_tok_index = token_index_reg;
    end

    // result at a newline
    always_comb
    begin
        fin_status = et_status;
        if ((et_status == ST_OK) && (et_cmd != CMD_QUIT) && (et_tok_index < TOK_W'(2)))
            fin_status = ST_ZERO_ID;

        for (int j = 0; j < 4; j++)
            res_args[j] = 32'd0;

        new_res = '0;
        if (overflow_reg)
        begin
            new_res.status = ST_TOO_LNG;
        end
        else if (fin_status == ST_UNKNOWN)
        begin
            new_res.status = ST_UNKNOWN;
        end
        else if (fin_status == ST_ZERO_ID)
        begin
            new_res.command = et_cmd;
            new_res.status  = ST_ZERO_ID;
        end
        else
        begin
            new_res.command = et_cmd;
            if (et_cmd != CMD_QUIT)
            begin
                for (int j = 0; j < OUT_ARGS; j++)
                    res_args[j] = et_args[j];
                new_res.target_id = et_id;
                new_res.arg_x     = res_args[0];
                new_res.arg_y     = res_args[1];
                new_res.arg_w     = res_args[2];
                new_res.arg_h     = res_args[3];
            end
        end
    end

    // per-byte state update
    always_comb
    begin
        token_index_next   = token_index_reg;
        keyword_match_next = keyword_match_reg;
        keyword_pos_next   = keyword_pos_reg;
        number_accum_next  = number_accum_reg;
        number_neg_next    = number_neg_reg;
        phase_next         = phase_reg;
        parsed_id_next     = parsed_id_reg;
        for (int j = 0; j < ARG_SLOTS; j++)
            parsed_args_next[j] = parsed_args_reg[j];
        line_length_next   = line_length_reg;
        overflow_next      = overflow_reg;
        line_cmd_next      = line_cmd_reg;
        line_status_next   = line_status_reg;

        if (accept)
        begin
            if (is_nl)
            begin
                // back to the start of a line
                token_index_next   = '0;
                keyword_match_next = '1;
                keyword_pos_next   = 3'd0;
                number_accum_next  = 32'd0;
                number_neg_next    = 1'b0;
                phase_next         = PH_LEAD;
                parsed_id_next     = 32'd0;
                for (int j = 0; j < ARG_SLOTS; j++)
                    parsed_args_next[j] = 32'd0;
                line_length_next   = '0;
                overflow_next      = 1'b0;
                line_cmd_next      = CMD_REBOX;
                line_status_next   = ST_OK;
            end
            else
            begin
                if (line_length_reg < LEN_W'(MAX_LINE))
                    line_length_next = line_length_reg + LEN_W'(1);
                if (line_length_next >= LEN_W'(MAX_LINE))
                    overflow_next = 1'b1;

                if (is_sp)
                begin
                    token_index_next  = et_tok_index;
                    line_cmd_next     = et_cmd;
                    line_status_next  = et_status;
                    parsed_id_next    = et_id;
                    for (int j = 0; j < ARG_SLOTS; j++)
                        parsed_args_next[j] = et_args[j];
                    number_accum_next = 32'd0;
                    number_neg_next   = 1'b0;
                    phase_next        = PH_LEAD;
                end
                else if (token_index_reg == '0)
                begin
                    // keyword matching, one position per byte
                    for (int k = 0; k < KW_COUNT; k++)
                    begin
                        if ((keyword_pos_reg >= KW_LEN[k]) || (kw_char(k, keyword_pos_reg) != c))
                            keyword_match_next[k] = 1'b0;
                    end
                    if (keyword_pos_reg != 3'd7)
                        keyword_pos_next = keyword_pos_reg + 3'd1;
                end
                else if (phase_reg != PH_DONE)
                begin
                    if (is_digit)
                    begin
                        // accum * 10 + digit, wraps mod 2^32
                        number_accum_next = (number_accum_reg << 3) + (number_accum_reg << 1)
                                          + {28'd0, c[3:0]};
                        phase_next        = PH_DIGITS;
                    end
                    else if ((phase_reg == PH_LEAD) && is_ws)
                    begin
                        phase_next = PH_LEAD;
                    end
                    else if ((phase_reg == PH_LEAD) && ((c == CH_PLUS) || (c == CH_MINUS)))
                    begin
                        number_neg_next = (c == CH_MINUS);
                        phase_next      = PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
            end
        end
    end

    // output register with a skid stage behind it
    always_comb
    begin
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_valid_next = skid_valid_reg;
        out_free        = !out_valid_reg || res.ready;

        if (skid_valid_reg)
        begin
            if (res.ready)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (accept && is_nl)
        begin
            if (out_free)
            begin
                out_data_next  = new_res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = new_res;
                skid_valid_next = 1'b1;
            end
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_index_reg   <= '0;
            keyword_match_reg <= '1;
            keyword_pos_reg   <= 3'd0;
            number_accum_reg  <= 32'd0;
            number_neg_reg    <= 1'b0;
            phase_reg         <= PH_LEAD;
            parsed_id_reg     <= 32'd0;
            for (int j = 0; j < ARG_SLOTS; j++)
                parsed_args_reg[j] <= 32'd0;
            line_length_reg   <= '0;
            overflow_reg      <= 1'b0;
            line_cmd_reg      <= CMD_REBOX;
            line_status_reg   <= ST_OK;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end
        else
        begin
            token_index_reg   <= token_index_next;
            keyword_match_reg <= keyword_match_next;
            keyword_pos_reg   <= keyword_pos_next;
            number_accum_reg  <= number_accum_next;
            number_neg_reg    <= number_neg_next;
            phase_reg         <= phase_next;
            parsed_id_reg     <= parsed_id_next;
            for (int j = 0; j < ARG_SLOTS; j++)
                parsed_args_reg[j] <= parsed_args_next[j];
            line_length_reg   <= line_length_next;
            overflow_reg      <= overflow_next;
            line_cmd_reg      <= line_cmd_next;
            line_status_reg   <= line_status_next;
            out_valid_reg     <= out_valid_next;
            skid_valid_reg    <= skid_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign res.valid     = out_valid_reg;
    assign res.command   = out_data_reg.command;
    assign res.status    = out_data_reg.status;
    assign res.target_id = out_data_reg.target_id;
    assign res.arg_x     = out_data_reg.arg_x;
    assign res.arg_y     = out_data_reg.arg_y;
    assign res.arg_w     = out_data_reg.arg_w;
    assign res.arg_h     = out_data_reg.arg_h;

endmodule
